@@ rtl/lru_handle_cache_assert.svh @@
// Assertion macros for the handle cache top level.
// Requires clk_i and rst_ni in the scope of use.
`ifndef LRU_HANDLE_CACHE_ASSERT_SVH
`define LRU_HANDLE_CACHE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lhc check failed");

// Antecedent implies consequent in the next cycle.
`define LHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lhc check failed");

`endif

@@ rtl/lhc_pkg.sv @@
// Shared constants and types for the handle cache.
// No dependencies.
`default_nettype none
package lhc_pkg;
  localparam int ENTRIES     = 64;
  localparam int KEY_BITS    = 64;
  localparam int HANDLE_BITS = 16;
  localparam int MAX_RESULTS = 34;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int MAX_W       = 7;
  localparam int CMP_W       = (CNT_W > MAX_W) ? CNT_W : MAX_W;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 3;
  localparam logic [MAX_W-1:0] MAX_OPEN_RST = MAX_W'(32);

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PURGE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_PURGE  = 3'd2,
    KIND_CLOSE  = 3'd3,
    KIND_FULL   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   found;
    logic [IDX_W-1:0]       slot;
    logic [HANDLE_BITS-1:0] handle;
    logic                   hopen;
    logic                   last;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/lru_handle_cache.sv @@
// Top level of the handle cache: control sequencer, flags and counters.
// Depends on lhc_pkg, lhc_ram and lru_handle_cache_assert.svh.
//
// One item is processed at a time. A key search reads the key memory one slot
// per cycle. A hit lookup or insert then walks the recency order memory up to
// the entry's rank, a new insert walks all used ranks, a purge walks all used
// ranks. Compaction visits ranks from the oldest, skipping closed entries and
// emitting a close request for each open one. Each memory has a single read
// port. Results leave through an output register and a one-deep pending stage,
// so input items are taken while a result waits.
`default_nettype none
module lru_handle_cache (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,   // max_open
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // key[63:0], handle[79:64]
  input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // found[0], slot[6:1], handle_out[22:7], handle_open[23]
  output logic [2:0]       m_axis_tuser,  // kind[2:0]
  output logic             m_axis_tlast
);
  import lhc_pkg::*;

  localparam int DW = KEY_BITS + HANDLE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_WALK, ST_PCLOSE,
    ST_CHECK, ST_CRD, ST_CSLOT, ST_CEMIT, ST_FLUSH
  } state_e;

  state_e                 state_q, state_d;
  logic [MODE_W-1:0]      mode_q, mode_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [HANDLE_BITS-1:0] hin_q, hin_d;
  logic [MAX_W-1:0]       max_q, max_d;
  logic [ENTRIES-1:0]     valid_q, valid_d, is_open_q, is_open_d;
  logic [CNT_W-1:0]       used_q, used_d, open_cnt_q, open_cnt_d;
  logic [CNT_W-1:0]       ik_q, ik_d, dk_q, dk_d, last_q, last_d, r_q, r_d;
  logic                   dv_q, dv_d;
  logic                   hit_q, hit_d, free_v_q, free_v_d, found_q, found_d;
  logic                   new_q, new_d, was_open_q, was_open_d;
  logic [IDX_W-1:0]       tgt_q, tgt_d, free_q, free_d, carry_q, carry_d;
  logic [HANDLE_BITS-1:0] hh_q, hh_d;
  logic [NRES_W-1:0]      n_q, n_d;
  res_t                   out_q, out_d, pend_q, pend_d;
  logic                   out_v_q, out_v_d, pend_v_q, pend_v_d;

  logic                   dm_we, dm_re, om_we, om_re;
  logic [IDX_W-1:0]       dm_waddr, dm_raddr, om_waddr, om_raddr;
  logic [DW-1:0]          dm_wdata, dm_rdata;
  logic [IDX_W-1:0]       om_wdata, om_rdata;

  lhc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data_ram (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .re_i(dm_re), .raddr_i(dm_raddr), .rdata_o(dm_rdata)
  );

  lhc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_order_ram (
    .clk_i, .we_i(om_we), .waddr_i(om_waddr), .wdata_i(om_wdata),
    .re_i(om_re), .raddr_i(om_raddr), .rdata_o(om_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {out_q.hopen, out_q.handle, out_q.slot, out_q.found};
  assign m_axis_tlast  = out_q.last;

  always_comb begin
    logic             can_put, put, stop;
    res_t             res;
    logic [CNT_W-1:0] rm1;
    logic [IDX_W-1:0] s;
    state_d = state_q; mode_d = mode_q; key_d = key_q; hin_d = hin_q;
    max_d = max_q; valid_d = valid_q; is_open_d = is_open_q;
    used_d = used_q; open_cnt_d = open_cnt_q;
    ik_d = ik_q; dk_d = dk_q; last_d = last_q; r_d = r_q; dv_d = 1'b0;
    hit_d = hit_q; free_v_d = free_v_q; found_d = found_q; new_d = new_q;
    was_open_d = was_open_q; tgt_d = tgt_q; free_d = free_q; carry_d = carry_q;
    hh_d = hh_q; n_d = n_q; pend_d = pend_q; pend_v_d = pend_v_q;
    out_d = out_q; out_v_d = out_v_q & ~m_axis_tready;
    dm_we = 1'b0; dm_waddr = '0; dm_wdata = {hin_q, key_q};
    dm_re = 1'b0; dm_raddr = '0;
    om_we = 1'b0; om_waddr = '0; om_wdata = carry_q;
    om_re = 1'b0; om_raddr = '0;
    can_put = !pend_v_q || !out_v_q;
    put = 1'b0; stop = 1'b0;
    res = '{kind: KIND_LOOKUP, found: 1'b0, slot: '0, handle: '0, hopen: 1'b0, last: 1'b0};
    rm1 = r_q - CNT_W'(1);
    s = '0;

    if (cfg_we_i) begin
      max_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d = s_axis_tuser;
          key_d = s_axis_tdata[KEY_BITS-1:0];
          hin_d = s_axis_tdata[KEY_BITS +: HANDLE_BITS];
          n_d = '0; hit_d = 1'b0; free_v_d = 1'b0; ik_d = '0;
          if (s_axis_tuser != MODE_NONE) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (dv_q) begin
          if (valid_q[dk_q[IDX_W-1:0]]) begin
            if (!hit_q && dm_rdata[KEY_BITS-1:0] == key_q) begin
              hit_d = 1'b1;
              tgt_d = dk_q[IDX_W-1:0];
              hh_d = dm_rdata[KEY_BITS +: HANDLE_BITS];
            end
          end else if (!free_v_q) begin
            free_v_d = 1'b1;
            free_d = dk_q[IDX_W-1:0];
          end
        end
        if (ik_q < CNT_W'(ENTRIES)) begin
          dm_re = 1'b1; dm_raddr = ik_q[IDX_W-1:0];
          dv_d = 1'b1; dk_d = ik_q; ik_d = ik_q + CNT_W'(1);
        end else if (!dv_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        put = 1'b1;
        ik_d = '0; found_d = 1'b0; new_d = 1'b0;
        carry_d = tgt_q; last_d = used_q - CNT_W'(1);
        was_open_d = is_open_q[tgt_q];
        case (mode_q)
          MODE_LOOKUP: begin
            res.kind = KIND_LOOKUP;
            if (hit_q) begin
              res.found = 1'b1; res.slot = tgt_q; res.handle = hh_q;
              res.hopen = is_open_q[tgt_q];
              state_d = ST_WALK;
            end else begin
              state_d = ST_FLUSH;
            end
          end
          MODE_INSERT: begin
            res.kind = KIND_INSERT; res.handle = hin_q; res.hopen = 1'b1;
            if (hit_q) begin
              res.found = 1'b1; res.slot = tgt_q;
              if (!is_open_q[tgt_q]) begin
                open_cnt_d = open_cnt_q + CNT_W'(1);
              end
              is_open_d[tgt_q] = 1'b1;
              dm_we = 1'b1; dm_waddr = tgt_q;
              state_d = ST_WALK;
            end else if (used_q >= CNT_W'(ENTRIES) || !free_v_q) begin
              res.kind = KIND_FULL; res.handle = '0; res.hopen = 1'b0;
              state_d = ST_CHECK;
            end else begin
              res.slot = free_q;
              valid_d[free_q] = 1'b1; is_open_d[free_q] = 1'b1;
              used_d = used_q + CNT_W'(1);
              open_cnt_d = open_cnt_q + CNT_W'(1);
              dm_we = 1'b1; dm_waddr = free_q;
              new_d = 1'b1; carry_d = free_q; tgt_d = free_q; last_d = used_q;
              state_d = ST_WALK;
            end
          end
          MODE_PURGE: begin
            res.kind = KIND_PURGE;
            if (hit_q) begin
              res.found = 1'b1; res.slot = tgt_q; res.handle = hh_q;
              res.hopen = is_open_q[tgt_q];
              valid_d[tgt_q] = 1'b0; is_open_d[tgt_q] = 1'b0;
              used_d = used_q - CNT_W'(1);
              if (is_open_q[tgt_q]) begin
                open_cnt_d = open_cnt_q - CNT_W'(1);
              end
              state_d = ST_WALK;
            end else begin
              state_d = ST_FLUSH;
            end
          end
          default: begin
            put = 1'b0;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_WALK: begin
        if (dv_q) begin
          stop = (dk_q == last_q);
          if (mode_q == MODE_PURGE) begin
            if (found_q) begin
              om_we = 1'b1; om_waddr = dk_q[IDX_W-1:0] - IDX_W'(1); om_wdata = om_rdata;
            end
            if (om_rdata == tgt_q) begin
              found_d = 1'b1;
            end
          end else begin
            om_we = 1'b1; om_waddr = dk_q[IDX_W-1:0]; om_wdata = carry_q;
            carry_d = om_rdata;
            if (!new_q && om_rdata == tgt_q) begin
              stop = 1'b1;
            end
          end
        end
        if (!stop && ik_q <= last_q) begin
          om_re = 1'b1; om_raddr = ik_q[IDX_W-1:0];
          dv_d = 1'b1; dk_d = ik_q; ik_d = ik_q + CNT_W'(1);
        end else if (stop || !dv_q) begin
          case (mode_q)
            MODE_INSERT: state_d = ST_CHECK;
            MODE_PURGE:  state_d = was_open_q ? ST_PCLOSE : ST_FLUSH;
            default:     state_d = ST_FLUSH;
          endcase
        end
      end
      ST_PCLOSE: begin
        if (can_put) begin
          put = 1'b1;
          res.kind = KIND_CLOSE; res.found = 1'b1; res.slot = tgt_q; res.handle = hh_q;
          state_d = ST_FLUSH;
        end
      end
      ST_CHECK: begin
        r_d = used_q;
        state_d = (CMP_W'(open_cnt_q) > CMP_W'(max_q)) ? ST_CRD : ST_FLUSH;
      end
      ST_CRD: begin
        if (r_q <= CNT_W'(1) || CMP_W'(open_cnt_q) <= CMP_W'(max_q >> 1)
            || n_q >= NRES_W'(MAX_RESULTS)) begin
          state_d = ST_FLUSH;
        end else begin
          om_re = 1'b1; om_raddr = rm1[IDX_W-1:0];
          state_d = ST_CSLOT;
        end
      end
      ST_CSLOT: begin
        s = om_rdata;
        r_d = rm1;
        if (is_open_q[s]) begin
          dm_re = 1'b1; dm_raddr = s;
          tgt_d = s;
          state_d = ST_CEMIT;
        end else begin
          state_d = ST_CRD;
        end
      end
      ST_CEMIT: begin
        if (can_put) begin
          put = 1'b1;
          res.kind = KIND_CLOSE; res.found = 1'b1; res.slot = tgt_q;
          res.handle = dm_rdata[KEY_BITS +: HANDLE_BITS];
          is_open_d[tgt_q] = 1'b0;
          open_cnt_d = open_cnt_q - CNT_W'(1);
          state_d = ST_CRD;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (!out_v_q) begin
          out_d = pend_q; out_d.last = 1'b1; out_v_d = 1'b1;
          pend_v_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (put) begin
      n_d = n_q + NRES_W'(1);
      if (pend_v_q) begin
        out_d = pend_q; out_d.last = 1'b0; out_v_d = 1'b1;
      end
      pend_d = res; pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      max_q <= MAX_OPEN_RST;
      valid_q <= '0; is_open_q <= '0;
      used_q <= '0; open_cnt_q <= '0;
      dv_q <= 1'b0; out_v_q <= 1'b0; pend_v_q <= 1'b0;
      n_q <= '0;
    end else begin
      state_q <= state_d;
      max_q <= max_d;
      valid_q <= valid_d; is_open_q <= is_open_d;
      used_q <= used_d; open_cnt_q <= open_cnt_d;
      dv_q <= dv_d; out_v_q <= out_v_d; pend_v_q <= pend_v_d;
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; key_q <= key_d; hin_q <= hin_d;
    ik_q <= ik_d; dk_q <= dk_d; last_q <= last_d; r_q <= r_d;
    hit_q <= hit_d; free_v_q <= free_v_d; found_q <= found_d;
    new_q <= new_d; was_open_q <= was_open_d;
    tgt_q <= tgt_d; free_q <= free_d; carry_q <= carry_d;
    hh_q <= hh_d; out_q <= out_d; pend_q <= pend_d;
  end

`include "lru_handle_cache_assert.svh"

  `LHC_ASSERT_IMPL(a_open_le_used, 1'b1, open_cnt_q <= used_q)
  `LHC_ASSERT_IMPL(a_used_bound, 1'b1, used_q <= CNT_W'(ENTRIES))
  `LHC_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser != MODE_NONE, state_q == ST_SCAN)
  `LHC_ASSERT_IMPL(a_result_bound, 1'b1, n_q <= NRES_W'(MAX_RESULTS))

endmodule
`default_nettype wire

@@ rtl/lhc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module lhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ verif/tb_lru_handle_cache.sv @@
// Testbench for lru_handle_cache: random and directed lookup, insert and purge
// traffic, checked against a behavioral table model in a scoreboard class.
// Depends on lhc_pkg and the lru_handle_cache RTL.
`timescale 1ns / 1ps
module tb_lru_handle_cache;
  import lhc_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic        found;
    logic [5:0]  slot;
    logic [15:0] hnd;
    logic        hopen;
    logic        last;
  } reply_t;

  class cache_scoreboard;
    logic [63:0] keys[64];
    logic [15:0] hnds[64];
    bit          opened[64];
    bit          valid[64];
    int unsigned rank[64];
    int unsigned used;
    int unsigned nopen;
    int unsigned limit;
    reply_t      pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < 64; i++) begin
        valid[i] = 0;
        opened[i] = 0;
        rank[i] = 0;
      end
      used = 0;
      nopen = 0;
      limit = 32;
      errors = 0;
      pending.delete();
    endfunction

    function void push(kind_e k, bit f, int s, logic [15:0] h, bit o);
      reply_t r;
      r.kind = k;
      r.found = f;
      r.slot = s[5:0];
      r.hnd = h;
      r.hopen = o;
      r.last = 0;
      pending.push_back(r);
    endfunction

    function int slot_of_key(logic [63:0] k);
      for (int i = 0; i < 64; i++)
        if (valid[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function int slot_of_rank(int unsigned r);
      for (int i = 0; i < 64; i++)
        if (valid[i] && rank[i] == r) return i;
      return -1;
    endfunction

    function void move_front(int s);
      int unsigned r;
      r = rank[s];
      for (int i = 0; i < 64; i++)
        if (valid[i] && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function void note_item(logic [1:0] mode, logic [63:0] k, logic [15:0] h);
      int s;
      int n;
      int f;
      int unsigned r;
      bit was;
      s = slot_of_key(k);
      n = 0;
      if (mode == MODE_LOOKUP) begin
        if (s < 0) push(KIND_LOOKUP, 0, 0, 0, 0);
        else begin
          move_front(s);
          push(KIND_LOOKUP, 1, s, hnds[s], opened[s]);
        end
        n = 1;
      end else if (mode == MODE_INSERT) begin
        if (s >= 0) begin
          move_front(s);
          if (!opened[s]) nopen++;
          opened[s] = 1;
          hnds[s] = h;
          push(KIND_INSERT, 1, s, h, 1);
        end else if (used >= 64) push(KIND_FULL, 0, 0, 0, 0);
        else begin
          f = 0;
          while (valid[f]) f++;
          for (int j = 0; j < 64; j++)
            if (valid[j]) rank[j]++;
          valid[f] = 1;
          keys[f] = k;
          hnds[f] = h;
          opened[f] = 1;
          rank[f] = 0;
          used++;
          nopen++;
          push(KIND_INSERT, 0, f, h, 1);
        end
        n = 1;
        if (nopen > limit) begin
          for (r = used; r > 1; r--) begin
            if (nopen <= limit / 2 || n >= MAX_RESULTS) break;
            f = slot_of_rank(r - 1);
            if (f < 0 || !opened[f]) continue;
            opened[f] = 0;
            nopen--;
            push(KIND_CLOSE, 1, f, hnds[f], 0);
            n++;
          end
        end
      end else if (mode == MODE_PURGE) begin
        n = 1;
        if (s < 0) push(KIND_PURGE, 0, 0, 0, 0);
        else begin
          r = rank[s];
          was = opened[s];
          for (int i = 0; i < 64; i++)
            if (valid[i] && rank[i] > r) rank[i]--;
          valid[s] = 0;
          opened[s] = 0;
          rank[s] = 0;
          if (used > 0) used--;
          push(KIND_PURGE, 1, s, hnds[s], was);
          if (was) begin
            if (nopen > 0) nopen--;
            push(KIND_CLOSE, 1, s, hnds[s], 0);
            n = 2;
          end
        end
      end
      if (n > 0) pending[pending.size() - 1].last = 1;
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer kind=%0d", got.kind);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp k%0d f%0d s%0d h%h o%0d l%0d got k%0d f%0d s%0d h%h o%0d l%0d",
                   exp.kind, exp.found, exp.slot, exp.hnd, exp.hopen, exp.last,
                   got.kind, got.found, got.slot, got.hnd, got.hopen, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  cache_scoreboard sb;
  logic [63:0] key_pool[16];
  bit          hold_off;
  bit          rx_quiet;
  int          idle_cycles = 0;

  lru_handle_cache dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_item(logic [1:0] mode, logic [63:0] k, logic [15:0] h);
    s_axis_tvalid <= 1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {h, k};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(mode, k, h);
  endtask

  task automatic go_idle(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [6:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.limit = v;
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 15)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count, int ins_weight);
    int burst;
    int left;
    int m;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        m = $urandom_range(0, 99);
        if (m < ins_weight) send_item(MODE_INSERT, pick_key(), 16'($urandom));
        else if (m < ins_weight + 25) send_item(MODE_LOOKUP, pick_key(), 16'($urandom));
        else if (m < 97) send_item(MODE_PURGE, pick_key(), 16'($urandom));
        else send_item(MODE_NONE, pick_key(), 16'($urandom));
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 20));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        reply_t got;
        got.kind = kind_e'(m_axis_tuser);
        got.found = m_axis_tdata[0];
        got.slot = m_axis_tdata[6:1];
        got.hnd = m_axis_tdata[22:7];
        got.hopen = m_axis_tdata[23];
        got.last = m_axis_tlast;
        sb.check_reply(got);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    phase = 0;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end else if (rx_quiet) m_axis_tready <= 1;
      else begin
        phase = (phase + 1) % 40;
        m_axis_tready <= (phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    sb = new();
    sb.clear();
    hold_off = 0;
    rx_quiet = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_item(MODE_LOOKUP, key_pool[0], 16'h0);
    send_item(MODE_PURGE, key_pool[1], 16'hFFFF);
    send_item(MODE_INSERT, key_pool[0], 16'h0000);
    send_item(MODE_INSERT, key_pool[1], 16'hFFFF);
    send_item(MODE_LOOKUP, key_pool[0], 16'h1234);
    send_item(MODE_INSERT, key_pool[0], 16'hA5A5);
    send_item(MODE_NONE, key_pool[1], 16'h5A5A);
    send_item(MODE_PURGE, key_pool[1], 16'h0);
    send_item(MODE_LOOKUP, key_pool[1], 16'h0);
    send_item(MODE_INSERT, key_pool[2], 16'h0F0F);
    write_limit(7'd1);
    send_item(MODE_INSERT, key_pool[3], 16'h3333);
    send_item(MODE_INSERT, key_pool[3], 16'h4444);
    send_item(MODE_PURGE, key_pool[3], 16'h0);
    write_limit(7'd64);
    for (int i = 0; i < 66; i++) send_item(MODE_INSERT, 64'h1000 + i, 16'($urandom));
    write_limit(7'd0);
    send_item(MODE_INSERT, 64'h1000, 16'hBEEF);
    write_limit(7'd64);
    for (int i = 0; i < 48; i++) send_item(MODE_PURGE, 64'h1000 + i, 16'h0);
    write_limit(7'd3);
    hold_off = 1;
    random_phase(12, 55);
    drain();
    write_limit(7'd8);
    random_phase(12, 50);
    write_limit(7'd32);
    random_phase(10, 45);
    write_limit(7'd127);
    random_phase(8, 40);
    rx_quiet = 1;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/lhc_pkg.sv
rtl/lhc_ram.sv
rtl/lru_handle_cache.sv
verif/tb_lru_handle_cache.sv
